// ===== design/ictf_pkg.sv =====
`timescale 1ns / 1ps
package ictf_pkg;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic [9:0]         dt_ms;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
    } t_out_item;

    localparam int CoeffReset = 62259;
    localparam int GyroDiv = 16500;
    localparam int MaxSteps = 24;
    // The gyro divisor is 4 * 4125; this is ceil(2^44 / 4125).
    localparam logic [31:0] GyroRecip = 32'd4264772375;

    typedef logic signed [31:0] t_ang;

    function automatic t_ang atan_entry(input logic [4:0] idx);
        case (idx)
            5'd0: atan_entry = 32'sd2949120;
            5'd1: atan_entry = 32'sd1740967;
            5'd2: atan_entry = 32'sd919879;
            5'd3: atan_entry = 32'sd466945;
            5'd4: atan_entry = 32'sd234379;
            5'd5: atan_entry = 32'sd117304;
            5'd6: atan_entry = 32'sd58666;
            5'd7: atan_entry = 32'sd29335;
            5'd8: atan_entry = 32'sd14668;
            5'd9: atan_entry = 32'sd7334;
            5'd10: atan_entry = 32'sd3667;
            5'd11: atan_entry = 32'sd1833;
            5'd12: atan_entry = 32'sd917;
            5'd13: atan_entry = 32'sd458;
            5'd14: atan_entry = 32'sd229;
            5'd15: atan_entry = 32'sd115;
            5'd16: atan_entry = 32'sd57;
            5'd17: atan_entry = 32'sd29;
            5'd18: atan_entry = 32'sd14;
            5'd19: atan_entry = 32'sd7;
            5'd20: atan_entry = 32'sd4;
            5'd21: atan_entry = 32'sd2;
            5'd22: atan_entry = 32'sd1;
            default: atan_entry = 32'sd0;
        endcase
    endfunction

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_ROT   = 7'b0000100,
        ST_STEP  = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_BLEND = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic       start;
        logic       load;
        logic       rot;
        logic       step;
        logic       div_start;
        logic       div_step;
        logic       blend;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

endpackage

// ===== design/ictf_datapath.sv =====
`timescale 1ns / 1ps
module ictf_datapath #(
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ictf_pkg::t_cmd      i_cmd,
    input  logic [1:0]          i_axis,
    input  logic [4:0]          i_iter,
    input  ictf_pkg::t_in_item  i_item,
    input  logic [15:0]         i_coeff,
    output ictf_pkg::t_stat     o_stat,
    output ictf_pkg::t_out_item o_result
);
    // Vector after x256 scaling and growth fits in 27 bits; use 28.
    logic signed [27:0] r_x, n_x, r_y, n_y;
    logic signed [31:0] r_z, n_z;
    logic signed [15:0] r_ang [3];
    logic               r_zero;
    logic signed [15:0] cy, cx, gy;
    logic signed [27:0] xs, ys;

    // Gyro step: |gyro*dt*2^F| < 2^33, so the rounded magnitude over four fits
    // in 32 bits and a multiplication by the reciprocal of 4125 is exact.
    logic [31:0]        r_num;
    logic [19:0]        r_quo;
    logic               r_ddone;
    logic               r_dneg;
    logic signed [20:0] step_v;
    logic signed [36:0] prod_c;
    logic [35:0]        mag_c;
    logic [63:0]        recip_p;

    logic signed [51:0] num;
    logic signed [51:0] absn, rq;
    logic signed [21:0] sum;

    always_comb begin
        case (i_axis)
            2'd0: begin cy = i_item.accel_y; cx = i_item.accel_z; gy = i_item.gyro_x; end
            2'd1: begin cy = i_item.accel_x; cx = i_item.accel_z; gy = i_item.gyro_y; end
            default: begin cy = i_item.accel_x; cx = i_item.accel_y; gy = i_item.gyro_z; end
        endcase
    end

    assign xs = r_x >>> i_iter;
    assign ys = r_y >>> i_iter;

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (i_cmd.load) begin
            n_x = 28'(cx) <<< 8;
            n_y = 28'(cy) <<< 8;
            n_z = '0;
        end else if (i_cmd.rot) begin
            if (r_x < 0) begin
                if (r_y >= 0) begin
                    n_x = r_y; n_y = -r_x; n_z = 32'sd5898240;
                end else begin
                    n_x = -r_y; n_y = r_x; n_z = -32'sd5898240;
                end
            end
        end else if (i_cmd.step && !r_zero) begin
            if (r_y >= 0) begin
                n_x = r_x + ys; n_y = r_y - xs;
                n_z = r_z + ictf_pkg::atan_entry(i_iter);
            end else begin
                n_x = r_x - ys; n_y = r_y + xs;
                n_z = r_z - ictf_pkg::atan_entry(i_iter);
            end
        end
    end

    assign prod_c = 37'(gy) * $signed({27'd0, i_item.dt_ms});
    assign mag_c = (36'(prod_c < 0 ? -prod_c : prod_c) <<< ANGLE_FRAC_BITS)
                 + 36'(ictf_pkg::GyroDiv / 2);
    assign recip_p = 64'(r_num) * 64'(ictf_pkg::GyroRecip);

    assign step_v = r_dneg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

    always_comb begin
        sum = 22'(r_ang[i_axis]) + 22'(step_v);
        num = 52'(i_coeff) * 52'(sum) * (52'sd1 <<< (16 - ANGLE_FRAC_BITS))
            + 52'(17'd65536 - 17'(i_coeff)) * 52'(r_z);
        absn = (num < 0) ? -num : num;
        rq = (absn + (52'sd1 <<< (31 - ANGLE_FRAC_BITS))) >>> (32 - ANGLE_FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) r_ang[k] <= '0;
        end else if (i_cmd.blend) begin
            if (num < 0) begin
                if (rq > 52'sd32768) r_ang[i_axis] <= -16'sd32768;
                else r_ang[i_axis] <= 16'(-rq);
            end else begin
                if (rq > 52'sd32767) r_ang[i_axis] <= 16'sd32767;
                else r_ang[i_axis] <= 16'(rq);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        if (i_cmd.load) r_zero <= (cx == 0 && cy == 0);
        if (i_cmd.div_start) begin
            r_dneg  <= prod_c < 0;
            r_num   <= mag_c[33:2];
            r_ddone <= 1'b0;
        end else if (i_cmd.div_step) begin
            r_quo   <= recip_p[63:44];
            r_ddone <= 1'b1;
        end
    end

    assign o_stat.div_done = r_ddone;
    assign o_result.angle_x = r_ang[0];
    assign o_result.angle_y = r_ang[1];
    assign o_result.angle_z = r_ang[2];
endmodule

// ===== design/ictf_ctrl.sv =====
`timescale 1ns / 1ps
module ictf_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_out_free,
    input  ictf_pkg::t_stat i_stat,
    output ictf_pkg::t_cmd  o_cmd,
    output logic [1:0]      o_axis,
    output logic [4:0]      o_iter,
    output logic            o_busy,
    output logic            o_done
);
    localparam int NSteps = (CORDIC_STEPS < ictf_pkg::MaxSteps) ? CORDIC_STEPS
                                                               : ictf_pkg::MaxSteps;
    ictf_pkg::t_state r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic [4:0] r_iter, n_iter;

    always_comb begin
        n_state = r_state;
        n_axis = r_axis;
        n_iter = r_iter;
        o_cmd = '0;
        case (r_state)
            ictf_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = ictf_pkg::ST_LOAD;
                    n_axis = 2'd0;
                end
            end
            ictf_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state = ictf_pkg::ST_ROT;
            end
            ictf_pkg::ST_ROT: begin
                o_cmd.rot = 1'b1;
                n_iter = '0;
                n_state = ictf_pkg::ST_STEP;
            end
            ictf_pkg::ST_STEP: begin
                o_cmd.step = 1'b1;
                o_cmd.div_step = 1'b1;
                n_iter = r_iter + 5'd1;
                if (r_iter == 5'(NSteps - 1)) n_state = ictf_pkg::ST_DIV;
            end
            ictf_pkg::ST_DIV: begin
                if (i_stat.div_done) n_state = ictf_pkg::ST_BLEND;
                else o_cmd.div_step = 1'b1;
            end
            ictf_pkg::ST_BLEND: begin
                o_cmd.blend = 1'b1;
                if (r_axis == 2'd2) begin
                    n_state = ictf_pkg::ST_DONE;
                end else begin
                    n_axis = r_axis + 2'd1;
                    n_state = ictf_pkg::ST_LOAD;
                end
            end
            ictf_pkg::ST_DONE: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = ictf_pkg::ST_IDLE;
                end
            end
            default: n_state = ictf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ictf_pkg::ST_IDLE;
            r_axis <= '0;
            r_iter <= '0;
        end else begin
            r_state <= n_state;
            r_axis <= n_axis;
            r_iter <= n_iter;
        end
    end

    assign o_axis = r_axis;
    assign o_iter = r_iter;
    assign o_busy = (r_state != ictf_pkg::ST_IDLE);
    assign o_done = o_cmd.finish;
endmodule

// ===== design/imu_complementary_tilt_filter.sv =====
`timescale 1ns / 1ps
// Three-axis complementary tilt filter for a six-axis inertial sensor.
// The input channel (i_in_valid, o_in_stall, i_in_item) takes one item of raw
// accelerometer and gyro readings plus the elapsed milliseconds.
// The output channel (o_out_valid, i_out_stall, o_out_item) returns the three
// filtered tilt angles for that item, in units of 2^-ANGLE_FRAC_BITS degree.
// The APB port holds the blend coefficient at address 0.
// Each axis is handled in turn by one shared CORDIC unit, and the gyro step
// is formed by a reciprocal multiplication; each axis passes through the
// load, rotate, CORDIC step, divide and blend states, and the next item can
// be accepted only once the result of the last has been handed to the
// output register.
// One item is in work at a time; o_in_stall is high while it is.
// The result register holds its item while the receiver stalls; the next
// item is still accepted and computed, and its result waits until the held
// one has been handed over.
// Reset clears the stored angles to zero and the coefficient to 62259.
module imu_complementary_tilt_filter #(
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ictf_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ictf_pkg::t_out_item o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    logic [15:0] r_coeff;
    ictf_pkg::t_in_item r_item;
    ictf_pkg::t_cmd cmd;
    ictf_pkg::t_stat stat;
    ictf_pkg::t_out_item res;
    logic [1:0] axis;
    logic [4:0] iter;
    logic busy, done, r_out_valid, accept;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, r_coeff} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_coeff <= 16'(ictf_pkg::CoeffReset);
        else if (psel && penable && pwrite && paddr == 2'd0) r_coeff <= pwdata[15:0];
    end

    assign o_in_stall = busy;
    assign accept = i_in_valid && !busy;

    always_ff @(posedge i_clk) begin
        if (accept) r_item <= i_in_item;
    end

    ictf_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(accept),
        .i_out_free(!r_out_valid || !i_out_stall), .i_stat(stat),
        .o_cmd(cmd), .o_axis(axis), .o_iter(iter), .o_busy(busy), .o_done(done)
    );

    ictf_datapath #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_axis(axis), .i_iter(iter),
        .i_item(r_item), .i_coeff(r_coeff), .o_stat(stat), .o_result(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (done) r_out_valid <= 1'b1;
        else if (!i_out_stall) r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (done) o_out_item <= res;
    end

    assign o_out_valid = r_out_valid;
endmodule

// ===== test/imu_complementary_tilt_filter_checker.sv =====
`timescale 1ns / 1ps
module imu_complementary_tilt_filter_checker #(
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  ictf_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  ictf_pkg::t_out_item i_out_item,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_coeff,
    output int                  o_errors,
    output int                  o_pending
);
    logic [15:0]      coeff;
    logic signed [15:0] tilt_x, tilt_y, tilt_z;
    ictf_pkg::t_out_item angle_queue[$];

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0) return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint div_near(longint n, longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint tilt_atan2(longint y, longint x);
        longint z, t, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        x = x * 256;
        y = y * 256;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 90 * 65536;
            end else begin
                t = x; x = -y; y = t; z = -90 * 65536;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; z += longint'(ictf_pkg::atan_entry(5'(i)));
            end else begin
                x = x - ys; y = y + xs; z -= longint'(ictf_pkg::atan_entry(5'(i)));
            end
        end
        return z;
    endfunction

    function automatic logic signed [15:0] blend_axis(longint prev, longint gyro,
                                                      longint dt, longint acc);
        longint step, a, up, r;
        step = div_near(gyro * dt * (longint'(1) << ANGLE_FRAC_BITS), 16500);
        a = longint'(coeff);
        up = longint'(1) << (16 - ANGLE_FRAC_BITS);
        r = div_near(a * (prev + step) * up + (65536 - a) * acc, 65536 * up);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    assign o_pending = angle_queue.size();

    always @(posedge i_clk) begin
        ictf_pkg::t_out_item e, w;
        if (!i_rst_n) begin
            coeff <= 16'(ictf_pkg::CoeffReset);
            tilt_x <= 0; tilt_y <= 0; tilt_z <= 0;
            o_errors = 0;
        end else begin
            if (i_cfg_we) coeff <= i_cfg_coeff;
            if (i_in_valid && !i_in_stall) begin
                e.angle_x = blend_axis(tilt_x, i_in_item.gyro_x, i_in_item.dt_ms,
                    tilt_atan2(i_in_item.accel_y, i_in_item.accel_z));
                e.angle_y = blend_axis(tilt_y, i_in_item.gyro_y, i_in_item.dt_ms,
                    tilt_atan2(i_in_item.accel_x, i_in_item.accel_z));
                e.angle_z = blend_axis(tilt_z, i_in_item.gyro_z, i_in_item.dt_ms,
                    tilt_atan2(i_in_item.accel_x, i_in_item.accel_y));
                tilt_x <= e.angle_x; tilt_y <= e.angle_y; tilt_z <= e.angle_z;
                angle_queue.push_back(e);
            end
            if (i_out_valid && !i_out_stall) begin
                if (angle_queue.size() == 0) begin
                    report("unexpected item", 1, 0);
                end else begin
                    w = angle_queue.pop_front();
                    if (i_out_item.angle_x !== w.angle_x)
                        report("angle_x", i_out_item.angle_x, w.angle_x);
                    if (i_out_item.angle_y !== w.angle_y)
                        report("angle_y", i_out_item.angle_y, w.angle_y);
                    if (i_out_item.angle_z !== w.angle_z)
                        report("angle_z", i_out_item.angle_z, w.angle_z);
                end
            end
        end
    end
endmodule

// ===== test/imu_complementary_tilt_filter_tb.sv =====
`timescale 1ns / 1ps
module imu_complementary_tilt_filter_tb;
    logic i_clk = 0;
    logic i_rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    ictf_pkg::t_in_item in_item = '0;
    logic out_valid;
    logic out_stall = 0;
    ictf_pkg::t_out_item out_item;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [1:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;
    int errors, pending;
    int idle_cycles = 0;
    int stall_mode = 0;

    always #1 i_clk = ~i_clk;

    imu_complementary_tilt_filter DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    imu_complementary_tilt_filter_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .i_cfg_we(psel && penable && pwrite && pready), .i_cfg_coeff(pwdata[15:0]),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if (stall_mode == 0) out_stall <= 0;
        else if (stall_mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= ($urandom_range(0, 9) < 7);
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_coeff(input logic [15:0] v);
        @(posedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= 0; pwdata <= {16'b0, v};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic send(input ictf_pkg::t_in_item it);
        in_item <= it;
        in_valid <= 1;
        do @(posedge i_clk); while (in_stall);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(signed'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic ictf_pkg::t_in_item random_item();
        ictf_pkg::t_in_item it;
        it.accel_x = pick16(); it.accel_y = pick16(); it.accel_z = pick16();
        it.gyro_x = pick16(); it.gyro_y = pick16(); it.gyro_z = pick16();
        it.dt_ms = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 20));
        return it;
    endfunction

    initial begin
        ictf_pkg::t_in_item it;
        logic [15:0] coeffs[5];
        coeffs = '{16'd65535, 16'd6554, 16'd0, 16'd32768, 16'd62259};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Directed corners under the reset coefficient.
        for (int k = 0; k < 20; k++) begin
            it = '0;
            case (k)
                0: it = '0;
                1: it = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 10'h3ff};
                2: it = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 10'h3ff};
                3: it = '{16'h8000, 16'h0000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 10'd0};
                4: it = '{16'h0000, 16'h7fff, 16'h0000, 16'h0, 16'h0, 16'h0, 10'd1};
                5: it = '{16'hffff, 16'h0000, 16'hffff, 16'h1, 16'hffff, 16'h1, 10'd500};
                6: it = '{16'h0000, 16'h8000, 16'h7fff, 16'h0, 16'h0, 16'h0, 10'd0};
                default: it = random_item();
            endcase
            send(it);
        end
        in_valid <= 0;
        drain();
        for (int p = 0; p < 5; p++) begin
            write_coeff(coeffs[p]);
            stall_mode = p % 3;
            for (int n = 0; n < 280; n++) begin
                send(random_item());
                if ($urandom_range(0, 3) == 0) begin
                    in_valid <= 0;
                    repeat ($urandom_range(1, 200)) @(posedge i_clk);
                end
            end
            in_valid <= 0;
            drain();
        end
        stall_mode = 0;
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
